### hw/rtl/mat3i_pkg.sv
// shared constants for the 3x3 matrix inverse pipeline
// no dependencies; imported by the channel interfaces and mat3_inverse
package mat3i_pkg;

	localparam int ELEM_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF  = 16;

	localparam int THR_WIDTH = 31;
	localparam logic [THR_WIDTH-1:0] THR_RESET = THR_WIDTH'(1);

	// adjugate entry k = e[A]*e[B] - e[C]*e[D], row-major element numbering
	localparam int unsigned COF_A [9] = '{4, 7, 1, 6, 0, 3, 3, 6, 0};
	localparam int unsigned COF_B [9] = '{8, 2, 5, 5, 8, 2, 7, 1, 4};
	localparam int unsigned COF_C [9] = '{7, 1, 4, 3, 6, 0, 6, 0, 3};
	localparam int unsigned COF_D [9] = '{5, 8, 2, 8, 2, 5, 4, 7, 1};

endpackage

### hw/rtl/mat3i_if.sv
// valid/ready channel interfaces for the matrix inverse
// depends on mat3i_pkg for the default element width
interface mat3i_in_if
	import mat3i_pkg::*;
	#(parameter int W = ELEM_WIDTH_DEF) ();

	logic valid;
	logic ready;
	logic signed [W-1:0] in_r0c0, in_r0c1, in_r0c2;
	logic signed [W-1:0] in_r1c0, in_r1c1, in_r1c2;
	logic signed [W-1:0] in_r2c0, in_r2c1, in_r2c2;

	modport source (output valid, in_r0c0, in_r0c1, in_r0c2, in_r1c0, in_r1c1, in_r1c2,
		in_r2c0, in_r2c1, in_r2c2, input ready);
	modport sink (input valid, in_r0c0, in_r0c1, in_r0c2, in_r1c0, in_r1c1, in_r1c2,
		in_r2c0, in_r2c1, in_r2c2, output ready);

endinterface

interface mat3i_out_if
	import mat3i_pkg::*;
	#(parameter int W = ELEM_WIDTH_DEF) ();

	logic valid;
	logic ready;
	logic signed [W-1:0] out_r0c0, out_r0c1, out_r0c2;
	logic signed [W-1:0] out_r1c0, out_r1c1, out_r1c2;
	logic signed [W-1:0] out_r2c0, out_r2c1, out_r2c2;
	logic singular;

	modport source (output valid, out_r0c0, out_r0c1, out_r0c2, out_r1c0, out_r1c1,
		out_r1c2, out_r2c0, out_r2c1, out_r2c2, singular, input ready);
	modport sink (input valid, out_r0c0, out_r0c1, out_r0c2, out_r1c0, out_r1c1,
		out_r1c2, out_r2c0, out_r2c1, out_r2c2, singular, output ready);

endinterface

### hw/rtl/mat3_inverse.sv
// 3x3 matrix inverse by adjugate and determinant, fully pipelined
// depends on mat3i_pkg and the channel interfaces in mat3i_if.sv
//
// usage: one matrix per beat on mat_in (nine signed elements, FRAC_BITS
// fraction bits), one result per beat on mat_out. the result is the
// inverse, each element saturated to the element range, or the input
// copied unchanged with singular set when |det| <= det_threshold.
// det_threshold is loaded through det_threshold_we / det_threshold_wdata
// (reset value is 1); the user must load it only while the pipe is empty,
// the block itself does not enforce this. structure: seven stages of
// products, cofactors, determinant, magnitudes and threshold compare,
// then one restoring-division stage per quotient bit, nine dividers side
// by side, then the saturating output register.
// throughput: one matrix per cycle while mat_out is not stalled.
// reset clears every stage valid bit; payload registers are not reset.
// when mat_out is stalled the whole pipe holds; mat_in.ready drops only
// while a result sits in the output register and is not taken.
module mat3_inverse
	import mat3i_pkg::*;
	#(
	parameter int FRAC_BITS  = FRAC_BITS_DEF,
	parameter int ELEM_WIDTH = ELEM_WIDTH_DEF
	) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 det_threshold_we,
	input  logic [THR_WIDTH-1:0] det_threshold_wdata,
	mat3i_in_if.sink             mat_in,
	mat3i_out_if.source          mat_out
);

	localparam int E   = ELEM_WIDTH;
	localparam int F   = FRAC_BITS;
	localparam int PW  = 2 * E;
	localparam int CW  = 2 * E + 1;
	localparam int L   = E + 1;
	localparam int DW  = 3 * E + 3;
	localparam int NW  = 2 * E + 2 * F;
	localparam int RW  = ((NW > DW + E) ? NW : DW + E) + 1;
	localparam int TW  = THR_WIDTH + 2 * F;
	localparam int CMW = ((DW > TW) ? DW : TW) + 1;

	typedef logic signed [E-1:0] elem_t;

	logic [THR_WIDTH-1:0] thr_q;
	logic adv;

	elem_t e_in [9];

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	elem_t e_s1 [9], e_s2 [9], e_s3 [9], e_s4 [9], e_s5 [9], e_s6 [9];
	logic signed [PW-1:0] p_s1 [18];
	logic signed [CW-1:0] adj_s2 [9], adj_s3 [9], adj_s4 [9], adj_s5 [9];
	logic signed [E+L:0]  pl_s3 [3];
	logic signed [PW-1:0] ph_s3 [3];
	logic signed [DW-1:0] t_s4 [3];
	logic signed [DW-1:0] det_s5;
	logic [DW-1:0] dmag_s6;
	logic          dneg_s6;
	logic [CW-1:0] amag_s6 [9];
	logic          aneg_s6 [9];

	// division steps, index 0 is loaded by the threshold stage
	logic          v_sd    [E+1];
	elem_t         e_sd    [E+1][9];
	logic          sing_sd [E+1];
	logic [DW-1:0] d_sd    [E+1];
	logic [RW-1:0] rem_sd  [E+1][9];
	logic [E-1:0]  q_sd    [E+1][9];
	logic          neg_sd  [E+1][9];
	logic          big_sd  [E+1][9];

	logic  v_sout;
	elem_t res_sout [9];
	logic  sing_sout;

	assign adv = !v_sout || mat_out.ready;
	assign mat_in.ready = adv;

	assign e_in[0] = mat_in.in_r0c0;
	assign e_in[1] = mat_in.in_r0c1;
	assign e_in[2] = mat_in.in_r0c2;
	assign e_in[3] = mat_in.in_r1c0;
	assign e_in[4] = mat_in.in_r1c1;
	assign e_in[5] = mat_in.in_r1c2;
	assign e_in[6] = mat_in.in_r2c0;
	assign e_in[7] = mat_in.in_r2c1;
	assign e_in[8] = mat_in.in_r2c2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
		end else if (det_threshold_we) begin
			thr_q <= det_threshold_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_sd[0] <= 1'b0;
		end else if (adv) begin
			v_s1 <= mat_in.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_sd[0] <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			// s1: cofactor products
			for (int k = 0; k < 9; k++) begin
				p_s1[2*k]   <= e_in[COF_A[k]] * e_in[COF_B[k]];
				p_s1[2*k+1] <= e_in[COF_C[k]] * e_in[COF_D[k]];
			end
			// s2: cofactors
			for (int k = 0; k < 9; k++) begin
				adj_s2[k] <= CW'(p_s1[2*k]) - CW'(p_s1[2*k+1]);
			end
			// s3: first-row terms of det, cofactor split into low and high parts
			for (int j = 0; j < 3; j++) begin
				pl_s3[j] <= e_s2[j] * $signed({1'b0, adj_s2[3*j][L-1:0]});
				ph_s3[j] <= e_s2[j] * $signed(adj_s2[3*j][CW-1:L]);
			end
			// s4: recombine partial products
			for (int j = 0; j < 3; j++) begin
				t_s4[j] <= (DW'(ph_s3[j]) <<< L) + DW'(pl_s3[j]);
			end
			// s5: determinant
			det_s5 <= t_s4[0] + t_s4[1] + t_s4[2];
			// s6: magnitudes and signs
			dneg_s6 <= det_s5[DW-1];
			dmag_s6 <= det_s5[DW-1] ? DW'(-det_s5) : DW'(det_s5);
			for (int k = 0; k < 9; k++) begin
				aneg_s6[k] <= adj_s5[k][CW-1];
				amag_s6[k] <= adj_s5[k][CW-1] ? CW'(-adj_s5[k]) : CW'(adj_s5[k]);
			end
			// s7: singular test, quotient overflow test, dividend setup
			sing_sd[0] <= CMW'(dmag_s6) <= (CMW'(thr_q) << (2 * F));
			d_sd[0]    <= dmag_s6;
			for (int k = 0; k < 9; k++) begin
				rem_sd[0][k] <= RW'(amag_s6[k]) << (2 * F);
				big_sd[0][k] <= (RW'(amag_s6[k]) << (2 * F)) >= (RW'(dmag_s6) << E);
				neg_sd[0][k] <= aneg_s6[k] ^ dneg_s6;
				q_sd[0][k]   <= '0;
			end
			adj_s3 <= adj_s2;
			adj_s4 <= adj_s3;
			adj_s5 <= adj_s4;
			e_s1 <= e_in;
			e_s2 <= e_s1;
			e_s3 <= e_s2;
			e_s4 <= e_s3;
			e_s5 <= e_s4;
			e_s6 <= e_s5;
			e_sd[0] <= e_s6;
		end
	end

	// one quotient bit per stage, most significant first
	for (genvar k = 0; k < E; k++) begin : g_div
		localparam int SH = E - 1 - k;
		logic [RW:0] diff [9];

		always_comb begin
			for (int m = 0; m < 9; m++) begin
				diff[m] = {1'b0, rem_sd[k][m]} - {1'b0, RW'(d_sd[k]) << SH};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_sd[k+1] <= 1'b0;
			end else if (adv) begin
				v_sd[k+1] <= v_sd[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				for (int m = 0; m < 9; m++) begin
					rem_sd[k+1][m] <= diff[m][RW] ? rem_sd[k][m] : diff[m][RW-1:0];
					q_sd[k+1][m]   <= {q_sd[k][m][E-2:0], !diff[m][RW]};
				end
				neg_sd[k+1]  <= neg_sd[k];
				big_sd[k+1]  <= big_sd[k];
				sing_sd[k+1] <= sing_sd[k];
				d_sd[k+1]    <= d_sd[k];
				e_sd[k+1]    <= e_sd[k];
			end
		end
	end

	// output register: saturate and pick inverse or pass-through
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sout <= 1'b0;
		end else if (adv) begin
			v_sout <= v_sd[E];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sing_sout <= sing_sd[E];
			for (int m = 0; m < 9; m++) begin
				if (sing_sd[E]) begin
					res_sout[m] <= e_sd[E][m];
				end else if (neg_sd[E][m]) begin
					if (big_sd[E][m] || (q_sd[E][m][E-1] && |q_sd[E][m][E-2:0])) begin
						res_sout[m] <= {1'b1, {(E-1){1'b0}}};
					end else begin
						res_sout[m] <= -q_sd[E][m];
					end
				end else begin
					if (big_sd[E][m] || q_sd[E][m][E-1]) begin
						res_sout[m] <= {1'b0, {(E-1){1'b1}}};
					end else begin
						res_sout[m] <= q_sd[E][m];
					end
				end
			end
		end
	end

	assign mat_out.valid    = v_sout;
	assign mat_out.singular = sing_sout;
	assign mat_out.out_r0c0 = res_sout[0];
	assign mat_out.out_r0c1 = res_sout[1];
	assign mat_out.out_r0c2 = res_sout[2];
	assign mat_out.out_r1c0 = res_sout[3];
	assign mat_out.out_r1c1 = res_sout[4];
	assign mat_out.out_r1c2 = res_sout[5];
	assign mat_out.out_r2c0 = res_sout[6];
	assign mat_out.out_r2c1 = res_sout[7];
	assign mat_out.out_r2c2 = res_sout[8];

endmodule

### dv/mat3_inverse_tb.sv
// self-checking testbench for mat3_inverse: directed matrices, then random phases
// depends on mat3i_pkg, the channel interfaces in mat3i_if.sv and the mat3_inverse rtl
`timescale 1ns / 1ps

module mat3_inverse_tb
	import mat3i_pkg::*;
	();

	typedef logic [8:0][31:0] matrix_t;
	typedef struct packed {
		logic [8:0][31:0] e;
		logic             sing;
	} inverse_t;
	typedef struct {
		matrix_t  m;
		bit       typed;
		inverse_t want;
	} dir_row_t;

	localparam logic [31:0] ONE  = 32'h0001_0000;
	localparam logic [31:0] MAXV = 32'h7fff_ffff;
	localparam logic [31:0] MINV = 32'h8000_0000;
	localparam logic [THR_WIDTH-1:0] THR_MAX = {THR_WIDTH{1'b1}};
	localparam int PIPE_CYCLES = 60;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic det_threshold_we = 1'b0;
	logic [THR_WIDTH-1:0] det_threshold_wdata = '0;
	logic [THR_WIDTH-1:0] cur_threshold = THR_RESET;

	mat3i_in_if  in_if ();
	mat3i_out_if out_if ();

	mat3_inverse dut (
		.clk                 (clk),
		.arst_n              (arst_n),
		.det_threshold_we    (det_threshold_we),
		.det_threshold_wdata (det_threshold_wdata),
		.mat_in              (in_if),
		.mat_out             (out_if)
	);

	inverse_t expected_q[$];
	int errors = 0;
	int hold_cycles = 0;
	bit quiet = 1'b0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	initial begin
		in_if.valid = 1'b0;
		{in_if.in_r0c0, in_if.in_r0c1, in_if.in_r0c2} = '0;
		{in_if.in_r1c0, in_if.in_r1c1, in_if.in_r1c2} = '0;
		{in_if.in_r2c0, in_if.in_r2c1, in_if.in_r2c2} = '0;
		out_if.ready = 1'b0;
	end

	initial begin
		#5_000_000;
		$display("mat3_inverse test failed");
		$finish;
	end

	function automatic matrix_t mk(logic [31:0] a, b, c, d, e, f, g, h, i);
		matrix_t m;
		m[0] = a; m[1] = b; m[2] = c;
		m[3] = d; m[4] = e; m[5] = f;
		m[6] = g; m[7] = h; m[8] = i;
		return m;
	endfunction

	// exact adjugate / determinant at 256 bits, truncating divide, saturate
	function automatic inverse_t invert(matrix_t m, logic [THR_WIDTH-1:0] thr);
		logic signed [255:0] x[9];
		logic signed [255:0] adj[9];
		logic signed [255:0] det;
		logic [255:0] mdet, limit, mag, q;
		inverse_t r;
		bit neg;
		for (int i = 0; i < 9; i++)
			x[i] = {{224{m[i][31]}}, m[i]};
		adj[0] = x[4] * x[8] - x[7] * x[5];
		adj[1] = x[7] * x[2] - x[1] * x[8];
		adj[2] = x[1] * x[5] - x[4] * x[2];
		adj[3] = x[6] * x[5] - x[3] * x[8];
		adj[4] = x[0] * x[8] - x[6] * x[2];
		adj[5] = x[3] * x[2] - x[0] * x[5];
		adj[6] = x[3] * x[7] - x[6] * x[4];
		adj[7] = x[6] * x[1] - x[0] * x[7];
		adj[8] = x[0] * x[4] - x[3] * x[1];
		det = x[0] * adj[0] + x[1] * adj[3] + x[2] * adj[6];
		mdet = det[255] ? -det : det;
		limit = {225'b0, thr} << 32;
		if (mdet <= limit || mdet == 0) begin
			r.e = m;
			r.sing = 1'b1;
			return r;
		end
		for (int i = 0; i < 9; i++) begin
			neg = adj[i][255] ^ det[255];
			mag = adj[i][255] ? -adj[i] : adj[i];
			q = (mag << 32) / mdet;
			if (neg) begin
				if (q > 256'h8000_0000) q = 256'h8000_0000;
				r.e[i] = -q[31:0];
			end else begin
				if (q > 256'h7fff_ffff) q = 256'h7fff_ffff;
				r.e[i] = q[31:0];
			end
		end
		r.sing = 1'b0;
		return r;
	endfunction

	function automatic logic [31:0] small_elem();
		return $urandom_range(32'h6_0000) - 32'h3_0000;
	endfunction

	function automatic matrix_t random_matrix();
		matrix_t m;
		int kind;
		kind = $urandom_range(9);
		for (int i = 0; i < 9; i++)
			m[i] = (kind < 2) ? $urandom() : small_elem();
		case (kind)
			6: begin
				// third row: each element copied from the first row or set to zero
				for (int i = 0; i < 3; i++)
					m[6 + i] = ($urandom_range(1)) ? m[i] : 32'h0;
			end
			7: begin
				for (int i = 0; i < 3; i++) begin
					m[4 * i] = 32'h1 << $urandom_range(30);
					if ($urandom_range(1)) m[4 * i] = -m[4 * i];
				end
			end
			8: begin
				for (int i = 0; i < 9; i++)
					m[i] = ((i % 4 == 0) ? ONE : 32'h0) + $urandom_range(32'h800) - 32'h400;
			end
			9: begin
				for (int i = 0; i < 9; i++)
					m[i] = $urandom_range(32'h200) - 32'h100;
			end
			default: ;
		endcase
		return m;
	endfunction

	task automatic send(matrix_t m, bit may_idle);
		in_if.valid <= 1'b1;
		in_if.in_r0c0 <= m[0]; in_if.in_r0c1 <= m[1]; in_if.in_r0c2 <= m[2];
		in_if.in_r1c0 <= m[3]; in_if.in_r1c1 <= m[4]; in_if.in_r1c2 <= m[5];
		in_if.in_r2c0 <= m[6]; in_if.in_r2c1 <= m[7]; in_if.in_r2c2 <= m[8];
		do @(posedge clk); while (!in_if.ready);
		expected_q.push_back(invert(m, cur_threshold));
		if (may_idle && !quiet && $urandom_range(99) < 7) begin
			in_if.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	task automatic drain();
		in_if.valid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (PIPE_CYCLES) @(posedge clk);
	endtask

	task automatic set_threshold(logic [THR_WIDTH-1:0] thr);
		det_threshold_we <= 1'b1;
		det_threshold_wdata <= thr;
		@(posedge clk);
		det_threshold_we <= 1'b0;
		cur_threshold = thr;
		@(posedge clk);
	endtask

	// receiving side: check the beat, then choose next ready
	always @(posedge clk) begin
		inverse_t got, want;
		if (out_if.valid && out_if.ready) begin
			got.e = mk(out_if.out_r0c0, out_if.out_r0c1, out_if.out_r0c2,
				out_if.out_r1c0, out_if.out_r1c1, out_if.out_r1c2,
				out_if.out_r2c0, out_if.out_r2c1, out_if.out_r2c2);
			got.sing = out_if.singular;
			if (expected_q.size() == 0) begin
				$display("%0t: result beat with nothing expected", $time);
				errors++;
			end else begin
				want = expected_q.pop_front();
				for (int i = 0; i < 9; i++)
					if (got.e[i] !== want.e[i]) begin
						$display("%0t: out_r%0dc%0d expected %0d actual %0d", $time,
							i / 3, i % 3, $signed(want.e[i]), $signed(got.e[i]));
						errors++;
					end
				if (got.sing !== want.sing) begin
					$display("%0t: singular expected %0b actual %0b", $time,
						want.sing, got.sing);
					errors++;
				end
			end
		end
		if (hold_cycles > 0) begin
			hold_cycles--;
			out_if.ready <= 1'b0;
		end else begin
			out_if.ready <= arst_n && (quiet || $urandom_range(99) >= 7);
		end
	end

	initial begin
		dir_row_t rows[$];
		logic [THR_WIDTH-1:0] phase_thr[5];
		inverse_t w;
		matrix_t m;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed part runs at the reset threshold
		m = '0;
		rows.push_back('{m, 1'b1, '{m, 1'b1}});
		m = {9{MINV}};
		rows.push_back('{m, 1'b1, '{m, 1'b1}});
		m = {9{MAXV}};
		rows.push_back('{m, 1'b1, '{m, 1'b1}});
		m = {9{32'hffff_ffff}};
		rows.push_back('{m, 1'b1, '{m, 1'b1}});
		m = mk(ONE, 0, 0, 0, ONE, 0, 0, 0, ONE);
		rows.push_back('{m, 1'b1, '{m, 1'b0}});
		m = mk(32'h2_0000, 0, 0, 0, 32'h2_0000, 0, 0, 0, 32'h2_0000);
		w.e = mk(32'h8000, 0, 0, 0, 32'h8000, 0, 0, 0, 32'h8000);
		w.sing = 1'b0;
		rows.push_back('{m, 1'b1, w});
		m = mk(-ONE, 0, 0, 0, -ONE, 0, 0, 0, -ONE);
		rows.push_back('{m, 1'b1, '{m, 1'b0}});
		m = mk(32'h1000, 0, 0, 0, 32'h1000, 0, 0, 0, 32'h1000);
		w.e = mk(32'h10_0000, 0, 0, 0, 32'h10_0000, 0, 0, 0, 32'h10_0000);
		rows.push_back('{m, 1'b1, w});
		// determinant exactly at the threshold, then one step above it
		m = mk(ONE, 0, 0, 0, ONE, 0, 0, 0, 32'h1);
		rows.push_back('{m, 1'b1, '{m, 1'b1}});
		m = mk(ONE, 0, 0, 0, ONE, 0, 0, 0, 32'h2);
		rows.push_back('{m, 1'b0, '0});
		// huge quotients saturate both ways
		m = mk(32'h1, 0, 0, 0, 32'h4000_0000, 0, 0, 0, 32'h4000_0000);
		rows.push_back('{m, 1'b0, '0});
		m = mk(32'hffff_ffff, 0, 0, 0, 32'h4000_0000, 0, 0, 0, 32'h4000_0000);
		rows.push_back('{m, 1'b0, '0});
		m = mk(MINV, 0, 0, 0, MAXV, 0, 0, 0, ONE);
		rows.push_back('{m, 1'b0, '0});
		m = mk(MINV, MAXV, 32'h1234_5678, MAXV, MINV, 32'h8765_4321, 1, -1, ONE);
		rows.push_back('{m, 1'b0, '0});
		m = mk(32'h3_0000, 32'h1_8000, 32'hffff_4000, 32'h2000, 32'h2_0000, 32'h7000,
			32'hfffe_0000, 32'h4000, 32'h1_0000);
		rows.push_back('{m, 1'b0, '0});

		foreach (rows[i]) begin
			send(rows[i].m, 1'b1);
			if (rows[i].typed) expected_q[expected_q.size() - 1] = rows[i].want;
		end
		drain();

		phase_thr[0] = '0;
		phase_thr[1] = THR_MAX;
		phase_thr[2] = THR_WIDTH'(1);
		phase_thr[3] = THR_WIDTH'($urandom_range(32'h10_0000));
		phase_thr[4] = THR_WIDTH'($urandom());
		for (int p = 0; p < 5; p++) begin
			set_threshold(phase_thr[p]);
			quiet = (p == 3);
			for (int n = 0; n < 370; n++) begin
				// receiver stalls long while matrices keep coming
				if (p == 0 && n == 40) hold_cycles = 300;
				if (p == 2 && n == 150) drain();
				send(random_matrix(), 1'b1);
			end
			quiet = 1'b0;
			drain();
		end

		if (errors == 0 && expected_q.size() == 0) begin
			$display("mat3_inverse test passed");
		end else begin
			$display("mat3_inverse test failed");
		end
		$finish;
	end

endmodule

### files.f
hw/rtl/mat3i_pkg.sv
hw/rtl/mat3i_if.sv
hw/rtl/mat3_inverse.sv
dv/mat3_inverse_tb.sv
